@@ src/hec_pkg.sv @@
package hec_pkg;

	// field widths
	localparam int AXIS_W  = 8;
	localparam int IDX_W   = 24;
	localparam int NODE_W  = 24;
	localparam int PROD_W  = 2 * AXIS_W;
	localparam int SY_W    = 2 * AXIS_W + 2;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 2;

	// largest cell count used on any axis
	localparam int MAX_CELLS_PER_AXIS = 255;

	// start accepted to done strobe, in cycles
	localparam int PIPE_LAT = 2 * AXIS_W + 7;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_CELLS  = 2'd0,
		REG_Y_CELLS  = 2'd1,
		REG_Z_CELLS  = 2'd2,
		REG_PERIODIC = 2'd3
	} cfg_reg_t;

endpackage

@@ src/hex8_element_connectivity.sv @@
// from start: stages 1-2, dividers a and b, stages 21-23 to done; result held for one cycle
// throughput: one element index per cycle, busy stays low and start is never refused
// the rate is set by the pipeline: two 8-step restoring dividers, one step per stage
// the receiver cannot stall, so results leave on done and are never held back
// reset (arst_n low, asynchronous) empties the pipeline and sets 1x1x1 cells, lattice mode

module hex8_element_connectivity
	import hec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [IDX_W-1:0]     element_index,
	output logic                 done,
	output logic [NODE_W-1:0]    corner_one,
	output logic [NODE_W-1:0]    corner_two,
	output logic [NODE_W-1:0]    corner_three,
	output logic [NODE_W-1:0]    corner_four,
	output logic [NODE_W-1:0]    corner_five,
	output logic [NODE_W-1:0]    corner_six,
	output logic [NODE_W-1:0]    corner_seven,
	output logic [NODE_W-1:0]    corner_eight,
	output logic                 range_error
);

	// configuration registers
	logic [AXIS_W-1:0] x_cells_q, y_cells_q, z_cells_q;
	logic              periodic_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_cells_q  <= AXIS_W'(1);
			y_cells_q  <= AXIS_W'(1);
			z_cells_q  <= AXIS_W'(1);
			periodic_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_X_CELLS:  x_cells_q  <= cfg_data[AXIS_W-1:0];
				REG_Y_CELLS:  y_cells_q  <= cfg_data[AXIS_W-1:0];
				REG_Z_CELLS:  z_cells_q  <= cfg_data[AXIS_W-1:0];
				REG_PERIODIC: periodic_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// axis counts saturated to the supported maximum
	logic [AXIS_W-1:0] nx, ny, nz;

	always_comb begin
		nx = (32'(x_cells_q) > MAX_CELLS_PER_AXIS) ? AXIS_W'(MAX_CELLS_PER_AXIS) : x_cells_q;
		ny = (32'(y_cells_q) > MAX_CELLS_PER_AXIS) ? AXIS_W'(MAX_CELLS_PER_AXIS) : y_cells_q;
		nz = (32'(z_cells_q) > MAX_CELLS_PER_AXIS) ? AXIS_W'(MAX_CELLS_PER_AXIS) : z_cells_q;
	end

	// a new transaction can enter every cycle
	assign busy = 1'b0;

	// stage 1: layer size nx*ny
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [PROD_W-1:0] nxny_s1;

	// stage 2: cell total
	logic              v_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [PROD_W-1:0] nxny_s2;
	logic [IDX_W-1:0]  total_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= element_index;
		nxny_s1  <= PROD_W'(nx) * PROD_W'(ny);
		idx_s2   <= idx_s1;
		nxny_s2  <= nxny_s1;
		total_s2 <= IDX_W'(nxny_s1) * IDX_W'(nz);
	end

	// divider a: index / (nx*ny) gives k, one quotient bit per stage
	// entry 0 is stage 3, which also does the range check
	logic [AXIS_W:0]   ka_v_s;
	logic [AXIS_W:0]   ka_err_s;
	logic [IDX_W-1:0]  ka_rem_s [0:AXIS_W];
	logic [AXIS_W-1:0] ka_q_s   [0:AXIS_W];
	logic [PROD_W-1:0] ka_d_s   [0:AXIS_W];
	logic [IDX_W-1:0]  ka_trial [1:AXIS_W];
	logic [AXIS_W:1]   ka_take;

	always_comb begin
		for (int n = 1; n <= AXIS_W; n++) begin
			ka_trial[n] = IDX_W'(ka_d_s[n-1]) << (AXIS_W - n);
			ka_take[n]  = ka_rem_s[n-1] >= ka_trial[n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ka_v_s <= '0;
		end else begin
			ka_v_s <= {ka_v_s[AXIS_W-1:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		ka_err_s[0] <= idx_s2 >= total_s2;
		ka_rem_s[0] <= idx_s2;
		ka_q_s[0]   <= '0;
		ka_d_s[0]   <= nxny_s2;
		for (int n = 1; n <= AXIS_W; n++) begin
			ka_err_s[n] <= ka_err_s[n-1];
			ka_d_s[n]   <= ka_d_s[n-1];
			ka_q_s[n]   <= {ka_q_s[n-1][AXIS_W-2:0], ka_take[n]};
			ka_rem_s[n] <= ka_take[n] ? ka_rem_s[n-1] - ka_trial[n] : ka_rem_s[n-1];
		end
	end

	// divider b: remainder / nx gives j, final remainder is i
	logic [AXIS_W:0]   jb_v_s;
	logic [AXIS_W:0]   jb_err_s;
	logic [PROD_W-1:0] jb_rem_s [0:AXIS_W];
	logic [AXIS_W-1:0] jb_q_s   [0:AXIS_W];
	logic [AXIS_W-1:0] jb_k_s   [0:AXIS_W];
	logic [PROD_W-1:0] jb_trial [1:AXIS_W];
	logic [AXIS_W:1]   jb_take;

	always_comb begin
		for (int n = 1; n <= AXIS_W; n++) begin
			jb_trial[n] = PROD_W'(nx) << (AXIS_W - n);
			jb_take[n]  = jb_rem_s[n-1] >= jb_trial[n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jb_v_s <= '0;
		end else begin
			jb_v_s <= {jb_v_s[AXIS_W-1:0], ka_v_s[AXIS_W]};
		end
	end

	always_ff @(posedge clk) begin
		jb_err_s[0] <= ka_err_s[AXIS_W];
		jb_rem_s[0] <= ka_rem_s[AXIS_W][PROD_W-1:0];
		jb_q_s[0]   <= '0;
		jb_k_s[0]   <= ka_q_s[AXIS_W];
		for (int n = 1; n <= AXIS_W; n++) begin
			jb_err_s[n] <= jb_err_s[n-1];
			jb_k_s[n]   <= jb_k_s[n-1];
			jb_q_s[n]   <= {jb_q_s[n-1][AXIS_W-2:0], jb_take[n]};
			jb_rem_s[n] <= jb_take[n] ? jb_rem_s[n-1] - jb_trial[n] : jb_rem_s[n-1];
		end
	end

	// stage 21: next coordinates with wrap, node strides
	logic [AXIS_W-1:0] ci, cj, ck;
	logic [AXIS_W:0]   ci_inc, cj_inc, ck_inc;
	logic [AXIS_W:0]   ex, ey;

	always_comb begin
		ci     = jb_rem_s[AXIS_W][AXIS_W-1:0];
		cj     = jb_q_s[AXIS_W];
		ck     = jb_k_s[AXIS_W];
		ci_inc = (AXIS_W+1)'(ci) + (AXIS_W+1)'(1);
		cj_inc = (AXIS_W+1)'(cj) + (AXIS_W+1)'(1);
		ck_inc = (AXIS_W+1)'(ck) + (AXIS_W+1)'(1);
		ex     = (AXIS_W+1)'(nx) + (AXIS_W+1)'(!periodic_q);
		ey     = (AXIS_W+1)'(ny) + (AXIS_W+1)'(!periodic_q);
	end

	logic              v_s21, err_s21;
	logic [AXIS_W-1:0] i0_s21, j0_s21, k0_s21;
	logic [AXIS_W:0]   i1_s21, j1_s21, k1_s21;
	logic [AXIS_W:0]   sx_s21;
	logic [SY_W-1:0]   sy_s21;

	always_ff @(posedge clk) begin
		err_s21 <= jb_err_s[AXIS_W];
		i0_s21  <= ci;
		j0_s21  <= cj;
		k0_s21  <= ck;
		i1_s21  <= (periodic_q && ci_inc == (AXIS_W+1)'(nx)) ? '0 : ci_inc;
		j1_s21  <= (periodic_q && cj_inc == (AXIS_W+1)'(ny)) ? '0 : cj_inc;
		k1_s21  <= (periodic_q && ck_inc == (AXIS_W+1)'(nz)) ? '0 : ck_inc;
		sx_s21  <= ex;
		sy_s21  <= SY_W'(ex) * SY_W'(ey);
	end

	// stage 22: row and layer offsets, modulo the node width
	logic              v_s22, err_s22;
	logic [NODE_W-1:0] i0_s22, i1_s22;
	logic [NODE_W-1:0] y0_s22, y1_s22, z0_s22, z1_s22;

	always_ff @(posedge clk) begin
		err_s22 <= err_s21;
		i0_s22  <= NODE_W'(i0_s21);
		i1_s22  <= NODE_W'(i1_s21);
		y0_s22  <= NODE_W'(j0_s21) * NODE_W'(sx_s21);
		y1_s22  <= NODE_W'(j1_s21) * NODE_W'(sx_s21);
		z0_s22  <= NODE_W'(k0_s21) * NODE_W'(sy_s21);
		z1_s22  <= NODE_W'(k1_s21) * NODE_W'(sy_s21);
	end

	// stage 23: corner sums, zeroed on range error
	logic              v_s23, err_s23;
	logic [NODE_W-1:0] node_s23 [0:7];

	always_ff @(posedge clk) begin
		err_s23     <= err_s22;
		node_s23[0] <= err_s22 ? '0 : z0_s22 + y0_s22 + i0_s22;
		node_s23[1] <= err_s22 ? '0 : z0_s22 + y0_s22 + i1_s22;
		node_s23[2] <= err_s22 ? '0 : z0_s22 + y1_s22 + i1_s22;
		node_s23[3] <= err_s22 ? '0 : z0_s22 + y1_s22 + i0_s22;
		node_s23[4] <= err_s22 ? '0 : z1_s22 + y0_s22 + i0_s22;
		node_s23[5] <= err_s22 ? '0 : z1_s22 + y0_s22 + i1_s22;
		node_s23[6] <= err_s22 ? '0 : z1_s22 + y1_s22 + i1_s22;
		node_s23[7] <= err_s22 ? '0 : z1_s22 + y1_s22 + i0_s22;
	end

	// valid bits of the tail stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s21 <= 1'b0;
			v_s22 <= 1'b0;
			v_s23 <= 1'b0;
		end else begin
			v_s21 <= jb_v_s[AXIS_W];
			v_s22 <= v_s21;
			v_s23 <= v_s22;
		end
	end

	// result ports
	assign done         = v_s23;
	assign range_error  = err_s23;
	assign corner_one   = node_s23[0];
	assign corner_two   = node_s23[1];
	assign corner_three = node_s23[2];
	assign corner_four  = node_s23[3];
	assign corner_five  = node_s23[4];
	assign corner_six   = node_s23[5];
	assign corner_seven = node_s23[6];
	assign corner_eight = node_s23[7];

endmodule

@@ src/hec_checker.sv @@
module hec_checker
	import hec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              done,
	input  logic [NODE_W-1:0] corner_one,
	input  logic [NODE_W-1:0] corner_two,
	input  logic [NODE_W-1:0] corner_three,
	input  logic [NODE_W-1:0] corner_four,
	input  logic [NODE_W-1:0] corner_five,
	input  logic [NODE_W-1:0] corner_seven,
	input  logic              range_error
);

	// every result traces back to a transaction accepted a fixed time earlier
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start, PIPE_LAT) && !$past(busy, PIPE_LAT)))
		else $error("result without a matching transaction");

	// an out-of-range index gives zero on corners one, two, three, five and seven
	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_error) |-> (corner_one == '0 && corner_two == '0 &&
			corner_three == '0 && corner_five == '0 && corner_seven == '0))
		else $error("corners not cleared on range error");

	// the row step is the same on both x columns of the bottom face
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !range_error) |->
			(NODE_W'(corner_three - corner_two) == NODE_W'(corner_four - corner_one)))
		else $error("bottom face rows disagree");

	// the layer step is the same at two opposite corners
	a_layer_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !range_error) |->
			(NODE_W'(corner_five - corner_one) == NODE_W'(corner_seven - corner_three)))
		else $error("layer step differs across the cell");

endmodule

bind hex8_element_connectivity hec_checker u_hec_checker (.*);

@@ bench/hex8_element_connectivity_tb.sv @@
`timescale 1ns / 100ps

module hex8_element_connectivity_tb;
	import hec_pkg::*;

	// one set of corner node indices as the block returns it, corner one first
	typedef struct packed {
		logic [0:7][NODE_W-1:0] node;
		logic                   err;
	} corner_set_t;

	// one row of the directed table: grid setting, index and, where obvious, the answer
	typedef struct {
		logic [AXIS_W-1:0] nx;
		logic [AXIS_W-1:0] ny;
		logic [AXIS_W-1:0] nz;
		logic              per;
		logic [IDX_W-1:0]  idx;
		bit                typed;
		corner_set_t       want;
	} stim_row_t;

	localparam logic LATTICE  = 1'b0;
	localparam logic PERIODIC = 1'b1;

	// which corners step one cell along each axis
	localparam logic [0:7] X_STEP = 8'b0110_0110;
	localparam logic [0:7] Y_STEP = 8'b0011_0011;
	localparam logic [0:7] Z_STEP = 8'b0000_1111;

	localparam corner_set_t BEYOND_GRID  = '{node: '0, err: 1'b1};
	localparam corner_set_t ALL_ZERO     = '{node: '0, err: 1'b0};
	localparam corner_set_t UNIT_CUBE    = '{node: '{24'd0, 24'd1, 24'd3, 24'd2,
		24'd4, 24'd5, 24'd7, 24'd6}, err: 1'b0};
	localparam corner_set_t BIG_ORIGIN   = '{node: '{24'd0, 24'd1, 24'd257, 24'd256,
		24'd65536, 24'd65537, 24'd65793, 24'd65792}, err: 1'b0};
	localparam corner_set_t PREDICTED    = '0;

	localparam int N_PHASES        = 12;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int N_DIRECTED      = 23;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 start;
	logic                 busy;
	logic [IDX_W-1:0]     element_index;
	logic                 done;
	logic [NODE_W-1:0]    corner_one;
	logic [NODE_W-1:0]    corner_two;
	logic [NODE_W-1:0]    corner_three;
	logic [NODE_W-1:0]    corner_four;
	logic [NODE_W-1:0]    corner_five;
	logic [NODE_W-1:0]    corner_six;
	logic [NODE_W-1:0]    corner_seven;
	logic [NODE_W-1:0]    corner_eight;
	logic                 range_error;

	// bench copy of the grid registers
	logic [AXIS_W-1:0] grid_x   = 8'd1;
	logic [AXIS_W-1:0] grid_y   = 8'd1;
	logic [AXIS_W-1:0] grid_z   = 8'd1;
	logic              grid_per = LATTICE;

	corner_set_t pending_corners [$];
	int          mismatches = 0;

	// directed stimulus: extremes, both numbering modes, zero counts, out of range
	stim_row_t directed [N_DIRECTED] = '{
		'{8'd1,   8'd1,   8'd1,   LATTICE,  24'd0,        1'b1, UNIT_CUBE},
		'{8'd1,   8'd1,   8'd1,   LATTICE,  24'd1,        1'b1, BEYOND_GRID},
		'{8'd1,   8'd1,   8'd1,   LATTICE,  24'hFFFFFF,   1'b1, BEYOND_GRID},
		'{8'd1,   8'd1,   8'd1,   PERIODIC, 24'd0,        1'b1, ALL_ZERO},
		'{8'd255, 8'd255, 8'd255, LATTICE,  24'd0,        1'b1, BIG_ORIGIN},
		'{8'd255, 8'd255, 8'd255, LATTICE,  24'd16581374, 1'b0, PREDICTED},
		'{8'd255, 8'd255, 8'd255, LATTICE,  24'd16581375, 1'b1, BEYOND_GRID},
		'{8'd255, 8'd255, 8'd255, LATTICE,  24'hAAAAAA,   1'b0, PREDICTED},
		'{8'd255, 8'd255, 8'd255, PERIODIC, 24'd16581374, 1'b0, PREDICTED},
		'{8'd255, 8'd255, 8'd255, PERIODIC, 24'd0,        1'b0, PREDICTED},
		'{8'd255, 8'd255, 8'd255, PERIODIC, 24'h555555,   1'b0, PREDICTED},
		'{8'd0,   8'd255, 8'd255, LATTICE,  24'd0,        1'b1, BEYOND_GRID},
		'{8'd255, 8'd0,   8'd255, LATTICE,  24'd0,        1'b1, BEYOND_GRID},
		'{8'd255, 8'd255, 8'd0,   PERIODIC, 24'd0,        1'b1, BEYOND_GRID},
		'{8'd7,   8'd5,   8'd3,   LATTICE,  24'd52,       1'b0, PREDICTED},
		'{8'd7,   8'd5,   8'd3,   PERIODIC, 24'd52,       1'b0, PREDICTED},
		'{8'd7,   8'd5,   8'd3,   PERIODIC, 24'd104,      1'b0, PREDICTED},
		'{8'd7,   8'd5,   8'd3,   PERIODIC, 24'd105,      1'b1, BEYOND_GRID},
		'{8'd255, 8'd1,   8'd1,   PERIODIC, 24'd254,      1'b0, PREDICTED},
		'{8'd1,   8'd255, 8'd1,   PERIODIC, 24'd254,      1'b0, PREDICTED},
		'{8'd1,   8'd1,   8'd255, PERIODIC, 24'd254,      1'b0, PREDICTED},
		'{8'd1,   8'd1,   8'd255, LATTICE,  24'd254,      1'b0, PREDICTED},
		'{8'd2,   8'd2,   8'd2,   LATTICE,  24'd7,        1'b0, PREDICTED}
	};

	hex8_element_connectivity dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.element_index (element_index),
		.done          (done),
		.corner_one    (corner_one),
		.corner_two    (corner_two),
		.corner_three  (corner_three),
		.corner_four   (corner_four),
		.corner_five   (corner_five),
		.corner_six    (corner_six),
		.corner_seven  (corner_seven),
		.corner_eight  (corner_eight),
		.range_error   (range_error)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// corner node indices of one cell under the current grid setting
	function automatic corner_set_t predict_corners(input logic [IDX_W-1:0] idx);
		longint unsigned nx, ny, nz, total, i, j, k, a, b, c, sx, sy;
		corner_set_t     r;
		nx = (grid_x > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : grid_x;
		ny = (grid_y > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : grid_y;
		nz = (grid_z > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : grid_z;
		total = nx * ny * nz;
		if (total == 0 || idx >= total)
			return BEYOND_GRID;
		i = idx % nx;
		j = (idx / nx) % ny;
		k = idx / (nx * ny);
		sx = grid_per ? nx : nx + 1;
		sy = grid_per ? nx * ny : (nx + 1) * (ny + 1);
		r = ALL_ZERO;
		for (int n = 0; n < 8; n++) begin
			a = i + X_STEP[n];
			b = j + Y_STEP[n];
			c = k + Z_STEP[n];
			// periodic numbering wraps the far faces back onto the near ones
			if (grid_per) begin
				if (a >= nx) a -= nx;
				if (b >= ny) b -= ny;
				if (c >= nz) c -= nz;
			end
			r.node[n] = NODE_W'(c * sy + b * sx + a);
		end
		return r;
	endfunction

	// axis count for a random phase, zero and full scale included
	function automatic logic [AXIS_W-1:0] pick_axis();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2, 3, 4: return AXIS_W'($urandom_range(1, 8));
			default: return AXIS_W'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// stop issuing and let every pending transaction come back
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_corners.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// reprogram all four grid registers while the block is idle
	task automatic program_grid(input logic [AXIS_W-1:0] nx, ny, nz, input logic per);
		wait_idle();
		cfg_wen   <= 1'b1;
		cfg_index <= REG_X_CELLS;
		cfg_data  <= nx;
		@(posedge clk);
		cfg_index <= REG_Y_CELLS;
		cfg_data  <= ny;
		@(posedge clk);
		cfg_index <= REG_Z_CELLS;
		cfg_data  <= nz;
		@(posedge clk);
		cfg_index <= REG_PERIODIC;
		cfg_data  <= CFG_W'(per);
		@(posedge clk);
		cfg_wen  <= 1'b0;
		grid_x   = nx;
		grid_y   = ny;
		grid_z   = nz;
		grid_per = per;
	endtask

	// issue one element index, then idle for a random gap unless bursting
	task automatic send_element(input logic [IDX_W-1:0] idx, input corner_set_t want,
		input bit burst);
		int gap;
		start         <= 1'b1;
		element_index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_corners.push_back(want);
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result checker: every done strobe is matched against the oldest expectation
	always @(posedge clk) begin
		corner_set_t got, want;
		got.node = {corner_one, corner_two, corner_three, corner_four,
			corner_five, corner_six, corner_seven, corner_eight};
		got.err = range_error;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_corners.size() == 0) begin
				report_mismatch("result with no pending transaction");
			end else begin
				want = pending_corners.pop_front();
				for (int n = 0; n < 8; n++)
					if (got.node[n] !== want.node[n])
						report_mismatch($sformatf("corner %0d got %0d expected %0d",
							n + 1, got.node[n], want.node[n]));
				if (got.err !== want.err)
					report_mismatch($sformatf("range_error got %b expected %b",
						got.err, want.err));
			end
		end
	end

	// stimulus
	initial begin
		int unsigned total;
		logic [IDX_W-1:0] idx;
		bit burst;
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = REG_X_CELLS;
		cfg_data      = '0;
		start         = 1'b0;
		element_index = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table, reprogramming only where the grid setting changes
		for (int r = 0; r < N_DIRECTED; r++) begin
			if ({directed[r].nx, directed[r].ny, directed[r].nz, directed[r].per} !=
				{grid_x, grid_y, grid_z, grid_per})
				program_grid(directed[r].nx, directed[r].ny, directed[r].nz, directed[r].per);
			send_element(directed[r].idx, directed[r].typed ? directed[r].want :
				predict_corners(directed[r].idx), 1'b0);
		end

		// random phases, each with its own grid; every third phase back to back
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: program_grid(8'd255, 8'd255, 8'd255, LATTICE);
				1: program_grid(8'd255, 8'd255, 8'd255, PERIODIC);
				2: program_grid(8'd1, 8'd1, 8'd1, PERIODIC);
				default: program_grid(pick_axis(), pick_axis(), pick_axis(),
					logic'($urandom_range(0, 1)));
			endcase
			burst = (p % 3 == 2);
			total = grid_x * grid_y * grid_z;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// mostly cells inside the grid, some indices past the end
				if (total == 0 || $urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 3) == 0)
						idx = '1;
					else
						idx = IDX_W'($urandom_range(total, 24'hFFFFFF));
				end else begin
					idx = IDX_W'($urandom_range(0, total - 1));
				end
				send_element(idx, predict_corners(idx), burst);
			end
		end

		// drain and let the pipeline settle
		wait_idle();
		repeat (PIPE_LAT + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ hex8_element_connectivity.f @@
src/hec_pkg.sv
src/hex8_element_connectivity.sv
src/hec_checker.sv
bench/hex8_element_connectivity_tb.sv
